/* design/tss_pkg.sv */
`timescale 1ns / 1ps

package tss_pkg;

    localparam int NUM_STACKS  = 3;
    localparam int STACK_DEPTH = 64;
    localparam int STORE_SIZE  = NUM_STACKS * STACK_DEPTH;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 7;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ID_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int SUM_W  = ADDR_W + 1;

    // request queue between front and back; depth must be a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
    localparam logic [WORD_W-1:0] FAIL_WORD = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_POP   = 2'd1,
        K_PEEK  = 2'd2,
        K_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

    typedef enum logic {
        BS_IDLE,
        BS_READ
    } back_state_t;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] value;
        logic              bad;
        logic [CNT_W-1:0]  cap;
        logic [SUM_W-1:0]  base;
    } req_t;

endpackage

/* design/three_stacks_shared_store_core.sv */
`timescale 1ns / 1ps
// Path: request queue, then back end into its output register; a successful
//   pop or peek adds the registered store read. Throughput: one item a cycle
//   for push, query and failed requests while results are popped; a pop or
//   peek that succeeds holds the next item while the single store port reads.
// Reset: fill counts clear, capacity goes to 64, queues empty; store contents
//   stay undefined until written, with no clearing pass.

module three_stacks_shared_store_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: stack capacity
    input  logic                              cfg_we,
    input  logic [tss_pkg::CAP_W-1:0]         cfg_wdata,
    // request side
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        kind,
    input  logic [1:0]                        stack_id,
    input  logic signed [tss_pkg::WORD_W-1:0] push_value,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        status,
    output logic signed [tss_pkg::WORD_W-1:0] data,
    output logic                              is_empty
);

    // Front: holds the capacity register, checks stack number and capacity,
    // works out the region base and queues the classified item.
    // Back: owns fill counts and the shared store, executes one item at a
    // time and parks its result in the output register, so the front keeps
    // taking items, until its queue is full, while a result waits to be popped.

    logic          q_valid;
    logic          q_pop;
    tss_pkg::req_t q_item;

    tss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .stack_id  (stack_id),
        .push_value(push_value),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    tss_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .empty   (empty),
        .pop     (pop),
        .status  (status),
        .data    (data),
        .is_empty(is_empty)
    );

endmodule

/* design/tss_ram.sv */
`timescale 1ns / 1ps

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tss_front.sv */
`timescale 1ns / 1ps

module tss_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tss_pkg::CAP_W-1:0]         cfg_wdata,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        kind,
    input  logic [1:0]                        stack_id,
    input  logic signed [tss_pkg::WORD_W-1:0] push_value,
    output logic                              q_valid,
    input  logic                              q_pop,
    output tss_pkg::req_t                     q_item
);

    logic [tss_pkg::CAP_W-1:0]  cap_reg;
    logic [tss_pkg::CNT_W-1:0]  cap_eff;
    tss_pkg::req_t              req;

    tss_pkg::req_t              entry_reg [tss_pkg::QDEPTH];
    logic [tss_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [tss_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [tss_pkg::QCNT_W-1:0] fill_reg, fill_next;
    logic                       do_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= tss_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // capacity saturates at the region size
    always_comb
    begin
        if (int'(cap_reg) > tss_pkg::STACK_DEPTH)
        begin
            cap_eff = tss_pkg::CNT_W'(tss_pkg::STACK_DEPTH);
        end
        else
        begin
            cap_eff = tss_pkg::CNT_W'(cap_reg);
        end
    end

    always_comb
    begin
        req.kind  = kind;
        req.id    = tss_pkg::ID_W'(stack_id);
        req.value = push_value;
        req.bad   = (cap_eff == '0) || (int'(stack_id) >= tss_pkg::NUM_STACKS);
        req.cap   = cap_eff;
        req.base  = tss_pkg::SUM_W'(tss_pkg::SUM_W'(stack_id) * tss_pkg::SUM_W'(cap_eff));
    end

    assign full    = (fill_reg == tss_pkg::QCNT_W'(tss_pkg::QDEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = entry_reg[rptr_reg];
    assign do_push = push && !full;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (do_push && !(q_pop && q_valid))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!do_push && q_pop && q_valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= req;
        end
    end

endmodule

/* design/tss_back.sv */
`timescale 1ns / 1ps

module tss_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  tss_pkg::req_t                     q_item,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        status,
    output logic signed [tss_pkg::WORD_W-1:0] data,
    output logic                              is_empty
);

    tss_pkg::back_state_t       state_reg, state_next;
    logic [tss_pkg::CNT_W-1:0]  cnt_reg [tss_pkg::NUM_STACKS];
    logic [tss_pkg::CNT_W-1:0]  cnt_next [tss_pkg::NUM_STACKS];

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [tss_pkg::WORD_W-1:0] data_reg, data_next;
    logic                       empty_reg, empty_next;

    logic                       out_free;
    logic [tss_pkg::CNT_W-1:0]  cnt;
    logic [tss_pkg::SUM_W-1:0]  addr_sum;
    logic                       ram_we, ram_re;
    logic [tss_pkg::ADDR_W-1:0] ram_addr;
    logic [tss_pkg::WORD_W-1:0] ram_rdata;

    tss_ram #(
        .WIDTH(tss_pkg::WORD_W),
        .DEPTH(tss_pkg::STORE_SIZE)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(q_item.value),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || pop;
    assign cnt      = cnt_reg[q_item.id];
    assign ram_addr = addr_sum[tss_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        status_next    = status_reg;
        data_next      = data_reg;
        empty_next     = empty_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        addr_sum       = q_item.base + tss_pkg::SUM_W'(cnt);

        unique case (state_reg)
            tss_pkg::BS_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = tss_pkg::ST_OK;
                    data_next      = tss_pkg::FAIL_WORD;
                    empty_next     = 1'b0;
                    if (q_item.bad)
                    begin
                        status_next = tss_pkg::ST_BAD;
                        empty_next  = 1'b1;
                    end
                    else
                    begin
                        unique case (q_item.kind)
                            tss_pkg::K_PUSH:
                            begin
                                if (cnt >= q_item.cap)
                                begin
                                    status_next = tss_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ram_we               = 1'b1;
                                    cnt_next[q_item.id]  = cnt + 1'b1;
                                end
                            end
                            tss_pkg::K_POP, tss_pkg::K_PEEK:
                            begin
                                if (cnt == '0)
                                begin
                                    status_next = tss_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    // word comes back next cycle
                                    addr_sum       = q_item.base + tss_pkg::SUM_W'(cnt)
                                                     - 1'b1;
                                    ram_re         = 1'b1;
                                    out_valid_next = 1'b0;
                                    state_next     = tss_pkg::BS_READ;
                                    if (q_item.kind == tss_pkg::K_POP)
                                    begin
                                        cnt_next[q_item.id] = cnt - 1'b1;
                                    end
                                end
                            end
                            tss_pkg::K_QUERY:
                            begin
                                empty_next = (cnt == '0);
                            end
                            default:
                            begin
                                status_next = tss_pkg::ST_BAD;
                            end
                        endcase
                    end
                end
            end
            tss_pkg::BS_READ:
            begin
                // output slot was freed when the read was issued
                out_valid_next = 1'b1;
                status_next    = tss_pkg::ST_OK;
                data_next      = ram_rdata;
                empty_next     = 1'b0;
                state_next     = tss_pkg::BS_IDLE;
            end
            default:
            begin
                state_next = tss_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tss_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tss_pkg::NUM_STACKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        empty_reg  <= empty_next;
    end

    assign empty    = !out_valid_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign is_empty = empty_reg;

endmodule

/* tb/tb_three_stacks_shared_store_core.sv */
`timescale 1ns / 1ps

module tb_three_stacks_shared_store_core;

    // expected answer for one request
    typedef struct {
        tss_pkg::status_t status;
        logic [31:0]      data;
        logic             is_empty;
    } stack_answer_t;

    // Scoreboard: tracks capacity, fill counts and store contents, predicts
    // the answer of every accepted request and checks answers in order.
    class stack_answer_scoreboard;
        logic [31:0]   words [tss_pkg::STORE_SIZE];
        bit            written [tss_pkg::STORE_SIZE];
        int unsigned   fills [tss_pkg::NUM_STACKS];
        int unsigned   capacity_reg;
        stack_answer_t pending_answers [$];
        int            mismatch_count;

        function new();
            capacity_reg = 64;
            mismatch_count = 0;
            foreach (fills[i])
                fills[i] = 0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function void set_capacity(int unsigned value);
            capacity_reg = value & 32'h7F;
        endfunction

        // register value saturates at the per-stack region size
        function int unsigned usable_capacity();
            return (capacity_reg > tss_pkg::STACK_DEPTH) ? tss_pkg::STACK_DEPTH : capacity_reg;
        endfunction

        // false when a pop or peek on this stack would read a never-written entry
        function bit read_is_safe(logic [1:0] id);
            int unsigned cap;
            cap = usable_capacity();
            if (cap == 0 || id >= tss_pkg::NUM_STACKS || fills[id] == 0)
                return 1'b1;
            return written[id * cap + fills[id] - 1];
        endfunction

        function void note_request(tss_pkg::kind_t k, logic [1:0] id, logic [31:0] value);
            stack_answer_t ans;
            int unsigned   cap;
            int unsigned   cnt;
            int unsigned   addr;
            cap = usable_capacity();
            ans.status = tss_pkg::ST_OK;
            ans.data = tss_pkg::FAIL_WORD;
            ans.is_empty = 1'b0;
            if (cap == 0 || id >= tss_pkg::NUM_STACKS)
            begin
                ans.status = tss_pkg::ST_BAD;
                ans.is_empty = 1'b1;
            end
            else
            begin
                cnt = fills[id];
                case (k)
                    tss_pkg::K_PUSH:
                        if (cnt >= cap)
                            ans.status = tss_pkg::ST_FULL;
                        else
                        begin
                            addr = id * cap + cnt;
                            words[addr] = value;
                            written[addr] = 1'b1;
                            fills[id] = cnt + 1;
                        end
                    tss_pkg::K_POP, tss_pkg::K_PEEK:
                        if (cnt == 0)
                            ans.status = tss_pkg::ST_EMPTY;
                        else
                        begin
                            ans.data = words[id * cap + cnt - 1];
                            if (k == tss_pkg::K_POP)
                                fills[id] = cnt - 1;
                        end
                    default:
                        ans.is_empty = (cnt == 0);
                endcase
            end
            pending_answers.insert(pending_answers.size(), ans);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatch_count++;
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        endtask

        task check_answer(logic [1:0] got_status, logic [31:0] got_data, logic got_empty);
            stack_answer_t ans;
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected answer", got_data, 32'h0);
                return;
            end
            ans = pending_answers.pop_front();
            if (got_status !== ans.status)
                report_mismatch("status", 32'(got_status), 32'(ans.status));
            if (got_data !== ans.data)
                report_mismatch("data", got_data, ans.data);
            if (got_empty !== ans.is_empty)
                report_mismatch("is_empty", 32'(got_empty), 32'(ans.is_empty));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [tss_pkg::CAP_W-1:0] cfg_wdata = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic [1:0]                kind = 2'd0;
    logic [1:0]                stack_id = 2'd0;
    logic signed [31:0]        push_value = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [1:0]                status;
    logic signed [31:0]        data;
    logic                      is_empty;

    stack_answer_scoreboard answers;

    // idle / stall odds in percent per cycle, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    three_stacks_shared_store_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .stack_id   (stack_id),
        .push_value (push_value),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .data       (data),
        .is_empty   (is_empty)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: check the answer taken at this edge, then pick the pop
    // level for the next cycle. Outputs are read before the edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            answers.check_answer(status, data, is_empty);
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Present one request and hold it until taken. A pop or peek that would
    // read a store entry nobody wrote turns into an empty query instead.
    task automatic send_request(tss_pkg::kind_t k, logic [1:0] id, logic [31:0] value);
        if ((k == tss_pkg::K_POP || k == tss_pkg::K_PEEK) && !answers.read_is_safe(id))
            k = tss_pkg::K_QUERY;
        push       <= 1'b1;
        kind       <= k;
        stack_id   <= id;
        push_value <= value;
        do
            @(posedge clk);
        while (full);
        answers.note_request(k, id, value);
        // idle cycles after the item, per-cycle odds
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Wait until every answer is back, plus slack for the store read stage.
    task automatic wait_drained();
        push <= 1'b0;
        while (answers.pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Capacity write; only called with the block idle.
    task automatic write_capacity(int unsigned value);
        cfg_wdata <= value[tss_pkg::CAP_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        answers.set_capacity(value);
    endtask

    // Random request. Fill bursts lean toward pushes so stacks reach full;
    // drain bursts lean toward pops so they hit empty. Most items go to one
    // focus stack; a few use the invalid stack number.
    task automatic random_request(bit filling, logic [1:0] focus);
        int unsigned    r;
        tss_pkg::kind_t k;
        logic [1:0]     id;
        logic [31:0]    value;
        r = $urandom_range(0, 99);
        if (filling)
            k = (r < 75) ? tss_pkg::K_PUSH : (r < 85) ? tss_pkg::K_POP :
                (r < 95) ? tss_pkg::K_PEEK : tss_pkg::K_QUERY;
        else
            k = (r < 20) ? tss_pkg::K_PUSH : (r < 65) ? tss_pkg::K_POP :
                (r < 90) ? tss_pkg::K_PEEK : tss_pkg::K_QUERY;
        r = $urandom_range(0, 99);
        id = (r < 85) ? focus : (r < 92) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 19))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = 32'h0000_0000;
            3:       value = 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
        send_request(k, id, value);
    endtask

    initial
    begin : stimulus
        int unsigned cap_plan [8];
        int unsigned burst_left;
        int unsigned seg_items;
        bit          filling;
        logic [1:0]  focus;

        answers = new();
        cap_plan = '{64, 5, 127, 1, 0, 33, 65, 0};
        cap_plan[7] = $urandom_range(2, 63);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset capacity of 64 ---
        // everything empty after reset
        send_request(tss_pkg::K_POP,   2'd0, 32'h0);
        send_request(tss_pkg::K_PEEK,  2'd1, 32'h0);
        send_request(tss_pkg::K_QUERY, 2'd2, 32'h0);
        // invalid stack number on every request kind
        send_request(tss_pkg::K_PUSH,  2'd3, 32'h1234_5678);
        send_request(tss_pkg::K_POP,   2'd3, 32'h0);
        send_request(tss_pkg::K_PEEK,  2'd3, 32'h0);
        send_request(tss_pkg::K_QUERY, 2'd3, 32'h0);
        // word extremes into each stack
        send_request(tss_pkg::K_PUSH,  2'd0, 32'h7FFF_FFFF);
        send_request(tss_pkg::K_PUSH,  2'd0, 32'h8000_0000);
        send_request(tss_pkg::K_PUSH,  2'd1, 32'hFFFF_FFFF);
        send_request(tss_pkg::K_PUSH,  2'd2, 32'h0000_0000);
        send_request(tss_pkg::K_PUSH,  2'd1, 32'h5555_5555);
        send_request(tss_pkg::K_PUSH,  2'd2, 32'hAAAA_AAAA);
        send_request(tss_pkg::K_QUERY, 2'd0, 32'h0);
        send_request(tss_pkg::K_PEEK,  2'd0, 32'h0);
        send_request(tss_pkg::K_POP,   2'd0, 32'h0);
        send_request(tss_pkg::K_POP,   2'd0, 32'h0);
        send_request(tss_pkg::K_POP,   2'd0, 32'h0);    // now empty
        send_request(tss_pkg::K_POP,   2'd1, 32'h0);
        send_request(tss_pkg::K_POP,   2'd1, 32'h0);
        send_request(tss_pkg::K_PEEK,  2'd2, 32'h0);
        send_request(tss_pkg::K_POP,   2'd2, 32'h0);
        wait_drained();

        // zero capacity: everything rejected
        write_capacity(0);
        send_request(tss_pkg::K_PUSH,  2'd0, 32'hDEAD_BEEF);
        send_request(tss_pkg::K_QUERY, 2'd1, 32'h0);
        wait_drained();

        // capacity one: second push hits full
        write_capacity(1);
        send_request(tss_pkg::K_PUSH,  2'd2, 32'h0BAD_F00D);
        send_request(tss_pkg::K_PUSH,  2'd2, 32'h0000_0001);
        send_request(tss_pkg::K_PEEK,  2'd2, 32'h0);
        wait_drained();

        // --- random phases ---
        // Fill counts carry over between phases, so capacity changes land
        // on stacks that still hold words, including counts above the new
        // capacity. Idling cycles through: none, sender, receiver, both.
        for (int seg = 0; seg < 8; seg++)
        begin
            write_capacity(cap_plan[seg]);
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 26;
                    recv_stall_pct = 26;
                end
            endcase
            seg_items = (cap_plan[seg] == 0) ? 40 : 140;
            burst_left = 0;
            filling = 1'b1;
            focus = 2'd0;
            for (int n = 0; n < seg_items; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(20, 120);
                    filling = $urandom_range(0, 1);
                    focus = 2'($urandom_range(0, 2));
                end
                burst_left--;
                random_request(filling, focus);
            end
            wait_drained();
        end

        if (answers.mismatch_count == 0)
            $display("PASS three_stacks_shared_store_core");
        else
            $display("FAIL three_stacks_shared_store_core");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL three_stacks_shared_store_core");
        $finish;
    end

endmodule

/* three_stacks_shared_store_core.f */
design/tss_pkg.sv
design/tss_ram.sv
design/tss_front.sv
design/tss_back.sv
design/three_stacks_shared_store_core.sv
tb/tb_three_stacks_shared_store_core.sv
